// File: hw/rtl/ceb_pkg.sv
// Shared constants for the cluster energy bin recalibrator.
// No dependencies; imported by every module of the block.
package ceb_pkg;

  localparam int ETA_BINS_MAX_DEF = 384;
  localparam int PHI_BINS_MAX_DEF = 64;
  localparam int PHI_SECTORS_DEF  = 32;

  localparam int FACTOR_W   = 16;
  localparam int ENERGY_W   = 24;
  localparam int ANGLE_W    = 16;
  localparam int ETA_W      = 16;
  localparam int FRAC_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [FACTOR_W-1:0] UNITY_Q12     = 16'd4096;
  localparam logic [ETA_W-1:0]    ETA_LIMIT_RST = 16'd4505;

  localparam logic [CFG_IDX_W-1:0] REG_ETA_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ETA_BINS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHI_BINS  = 2'd2;

  localparam logic FUNC_WRITE   = 1'b0;
  localparam logic FUNC_CLUSTER = 1'b1;

endpackage

// File: hw/rtl/ceb_div.sv
// Pipelined restoring divider with a sideband that travels alongside.
// Expects num < den << Q_W. Uses ceb_pkg.
module ceb_div import ceb_pkg::*; #(
  parameter int NUM_W  = 36,
  parameter int DEN_W  = 16,
  parameter int Q_W    = 24,
  parameter int SPS    = 2,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    out_quo,
  output logic [SIDE_W-1:0] out_side
);

  localparam int W   = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;
  localparam int NST = (Q_W + SPS - 1) / SPS;

  logic              vld_r  [NST];
  logic [W-1:0]      rem_r  [NST];
  logic [Q_W-1:0]    quo_r  [NST];
  logic [DEN_W-1:0]  den_r  [NST];
  logic [SIDE_W-1:0] side_r [NST];

  genvar s;
  for (s = 0; s < NST; s++) begin : g_st
    logic              v_i;
    logic [W-1:0]      rem_i;
    logic [Q_W-1:0]    quo_i;
    logic [DEN_W-1:0]  den_i;
    logic [SIDE_W-1:0] side_i;
    logic [W-1:0]      rem_nxt;
    logic [Q_W-1:0]    quo_nxt;

    if (s == 0) begin : g_src
      assign v_i    = in_valid;
      assign rem_i  = W'(in_num);
      assign quo_i  = '0;
      assign den_i  = in_den;
      assign side_i = in_side;
    end else begin : g_src
      assign v_i    = vld_r[s-1];
      assign rem_i  = rem_r[s-1];
      assign quo_i  = quo_r[s-1];
      assign den_i  = den_r[s-1];
      assign side_i = side_r[s-1];
    end

    always_comb begin
      logic [W-1:0] dsh;
      dsh     = '0;
      rem_nxt = rem_i;
      quo_nxt = quo_i;
      for (int j = 0; j < SPS; j++) begin
        if (s * SPS + j < Q_W) begin
          dsh = W'(den_i) << (Q_W - 1 - (s * SPS + j));
          if (rem_nxt >= dsh) begin
            rem_nxt = rem_nxt - dsh;
            quo_nxt[Q_W - 1 - (s * SPS + j)] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        quo_r[s]  <= quo_nxt;
        den_r[s]  <= den_i;
        side_r[s] <= side_i;
      end
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_quo   = quo_r[NST-1];
  assign out_side  = side_r[NST-1];

endmodule

// File: hw/rtl/ceb_tbl.sv
// Factor tables for total and core energy, one port each cycle, registered read.
// Sweeps every entry to unity after reset. Uses ceb_pkg.
module ceb_tbl import ceb_pkg::*; #(
  parameter int DEPTH = ETA_BINS_MAX_DEF * PHI_BINS_MAX_DEF,
  parameter int AW    = $clog2(ETA_BINS_MAX_DEF * PHI_BINS_MAX_DEF)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                we,
  input  logic [AW-1:0]       addr,
  input  logic [FACTOR_W-1:0] wdata_total,
  input  logic [FACTOR_W-1:0] wdata_core,
  output logic [FACTOR_W-1:0] rd_total,
  output logic [FACTOR_W-1:0] rd_core,
  output logic                busy
);

  logic [FACTOR_W-1:0] total_mem [DEPTH];
  logic [FACTOR_W-1:0] core_mem  [DEPTH];
  logic                clr_busy_r;
  logic [AW-1:0]       clr_cnt_r;
  logic [FACTOR_W-1:0] rd_total_r;
  logic [FACTOR_W-1:0] rd_core_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      total_mem[clr_cnt_r] <= UNITY_Q12;
      core_mem[clr_cnt_r]  <= UNITY_Q12;
    end else if (en) begin
      if (we) begin
        total_mem[addr] <= wdata_total;
        core_mem[addr]  <= wdata_core;
      end
      rd_total_r <= total_mem[addr];
      rd_core_r  <= core_mem[addr];
    end
  end

  assign rd_total = rd_total_r;
  assign rd_core  = rd_core_r;
  assign busy     = clr_busy_r;

endmodule

// File: hw/rtl/cluster_energy_bin_recalibrator.sv
// Top level: eta/phi binning, factor table lookup and energy division.
// Uses ceb_pkg, ceb_div and ceb_tbl.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | func, table bins, factors, cluster fields
//  out_    | output    | out_valid/out_stall| corrected energies, bins, divide fault
//  cfg_    | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item per cycle while out_stall and the reset table sweep do not hold the flow;
// the path runs through the eta divider (3 stages at default sizes) and the energy dividers (12 stages).
// After reset the tables are swept to unity entry by entry across all
// ETA_BINS_MAX * PHI_BINS_MAX entries (24576 at defaults); in_stall stays high meanwhile.
// An out_stall while out_valid is high freezes the whole pipeline; nothing is dropped or repeated.
module cluster_energy_bin_recalibrator import ceb_pkg::*; #(
  parameter int ETA_BINS_MAX = ETA_BINS_MAX_DEF,
  parameter int PHI_BINS_MAX = PHI_BINS_MAX_DEF,
  parameter int PHI_SECTORS  = PHI_SECTORS_DEF,
  localparam int EBW = (ETA_BINS_MAX > 1) ? $clog2(ETA_BINS_MAX) : 1,
  localparam int PBW = (PHI_BINS_MAX > 1) ? $clog2(PHI_BINS_MAX) : 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_func,
  input  logic [EBW-1:0]        in_table_eta_bin,
  input  logic [PBW-1:0]        in_table_phi_bin,
  input  logic [FACTOR_W-1:0]   in_total_factor,
  input  logic [FACTOR_W-1:0]   in_core_factor,
  input  logic signed [ANGLE_W-1:0] in_cluster_phi,
  input  logic [ETA_W-1:0]      in_cluster_abs_eta,
  input  logic [ENERGY_W-1:0]   in_cluster_energy,
  input  logic [ENERGY_W-1:0]   in_cluster_core,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ENERGY_W-1:0]   out_corrected_energy,
  output logic [ENERGY_W-1:0]   out_corrected_core,
  output logic [EBW-1:0]        out_eta_bin,
  output logic [PBW-1:0]        out_phi_bin,
  output logic                  out_divide_fault,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int EMW   = $clog2(ETA_BINS_MAX + 1);
  localparam int PMW   = $clog2(PHI_BINS_MAX + 1);
  localparam int DEPTH = ETA_BINS_MAX * PHI_BINS_MAX;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NUM_W = ENERGY_W + FRAC_W;

  typedef struct packed {
    logic                func;
    logic                wok;
    logic [EBW-1:0]      te;
    logic [PBW-1:0]      tp;
    logic [FACTOR_W-1:0] tf;
    logic [FACTOR_W-1:0] cf;
    logic [ENERGY_W-1:0] en;
    logic [ENERGY_W-1:0] co;
    logic [PBW-1:0]      pbin;
    logic                ge;
    logic [EBW-1:0]      mlast;
  } front_t;

  typedef struct packed {
    logic           sat;
    logic           fault;
    logic [EBW-1:0] ebin;
    logic [PBW-1:0] pbin;
  } back_t;

  // configuration
  logic [ETA_W-1:0] eta_limit_r;
  logic [EMW-1:0]   eta_bins_r;
  logic [PMW-1:0]   phi_bins_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eta_limit_r <= ETA_LIMIT_RST;
      eta_bins_r  <= EMW'(384);
      phi_bins_r  <= PMW'(64);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ETA_LIMIT: eta_limit_r <= cfg_data;
        REG_ETA_BINS:  eta_bins_r  <= cfg_data[EMW-1:0];
        REG_PHI_BINS:  phi_bins_r  <= cfg_data[PMW-1:0];
        default: ;
      endcase
    end
  end

  logic [EMW-1:0] m_cnt;
  logic [PMW-1:0] n_cnt;

  always_comb begin
    if (eta_bins_r == '0) m_cnt = EMW'(1);
    else if (eta_bins_r > EMW'(ETA_BINS_MAX)) m_cnt = EMW'(ETA_BINS_MAX);
    else m_cnt = eta_bins_r;
    if (phi_bins_r == '0) n_cnt = PMW'(1);
    else if (phi_bins_r > PMW'(PHI_BINS_MAX)) n_cnt = PMW'(PHI_BINS_MAX);
    else n_cnt = phi_bins_r;
  end

  // flow control
  logic adv;
  logic tbl_busy;
  logic in_xfer;
  logic out_valid_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = tbl_busy || !adv;
  assign in_xfer  = in_valid && !in_stall;

  // stage 0: phi fold, eta product
  logic [2*ANGLE_W-1:0]  phi_prod;
  logic [ANGLE_W-1:0]    r_pos;
  logic [ANGLE_W+PMW-1:0] rn_prod;
  front_t                f_nxt;

  always_comb begin
    phi_prod       = 32'($unsigned(in_cluster_phi)) * 32'(PHI_SECTORS);
    r_pos          = phi_prod[ANGLE_W-1:0] + 16'h8000;
    rn_prod        = (ANGLE_W+PMW)'(r_pos) * (ANGLE_W+PMW)'(n_cnt);
    f_nxt.func     = in_func;
    f_nxt.wok      = ({1'b0, in_table_eta_bin} < (EBW+1)'(ETA_BINS_MAX)) &&
                     ({1'b0, in_table_phi_bin} < (PBW+1)'(PHI_BINS_MAX));
    f_nxt.te       = in_table_eta_bin;
    f_nxt.tp       = in_table_phi_bin;
    f_nxt.tf       = in_total_factor;
    f_nxt.cf       = in_core_factor;
    f_nxt.en       = in_cluster_energy;
    f_nxt.co       = in_cluster_core;
    f_nxt.pbin     = rn_prod[ANGLE_W +: PBW];
    f_nxt.ge       = in_cluster_abs_eta >= eta_limit_r;
    f_nxt.mlast    = EBW'(m_cnt - 1'b1);
  end

  logic                 s1_vld_r;
  front_t               s1_r;
  logic [ETA_W+EMW-1:0] s1_mul_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r     <= f_nxt;
      s1_mul_r <= (ETA_W+EMW)'(in_cluster_abs_eta) * (ETA_W+EMW)'(m_cnt);
    end
  end

  // eta division
  logic           ed_vld;
  logic [EBW-1:0] ed_quo;
  front_t         ed_side;

  ceb_div #(
    .NUM_W (ETA_W + EMW),
    .DEN_W (ETA_W),
    .Q_W   (EBW),
    .SPS   (3),
    .SIDE_W($bits(front_t))
  ) u_eta_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (s1_vld_r),
    .in_num   (s1_r.ge ? '0 : s1_mul_r),
    .in_den   (eta_limit_r),
    .in_side  (s1_r),
    .out_valid(ed_vld),
    .out_quo  (ed_quo),
    .out_side (ed_side)
  );

  // address stage
  logic [EBW-1:0]      ebin;
  logic [AW-1:0]       addr_nxt;
  logic                a_vld_r;
  logic                a_func_r;
  logic                a_we_r;
  logic [AW-1:0]       a_addr_r;
  logic [FACTOR_W-1:0] a_tf_r;
  logic [FACTOR_W-1:0] a_cf_r;
  logic [ENERGY_W-1:0] a_en_r;
  logic [ENERGY_W-1:0] a_co_r;
  logic [EBW-1:0]      a_ebin_r;
  logic [PBW-1:0]      a_pbin_r;

  always_comb begin
    ebin = ed_side.ge ? ed_side.mlast : ed_quo;
    if (ed_side.func == FUNC_CLUSTER) begin
      addr_nxt = AW'(ebin) * AW'(PHI_BINS_MAX) + AW'(ed_side.pbin);
    end else begin
      addr_nxt = AW'(ed_side.te) * AW'(PHI_BINS_MAX) + AW'(ed_side.tp);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= ed_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_func_r <= ed_side.func;
      a_we_r   <= (ed_side.func == FUNC_WRITE) && ed_side.wok;
      a_addr_r <= addr_nxt;
      a_tf_r   <= ed_side.tf;
      a_cf_r   <= ed_side.cf;
      a_en_r   <= ed_side.en;
      a_co_r   <= ed_side.co;
      a_ebin_r <= ebin;
      a_pbin_r <= ed_side.pbin;
    end
  end

  // table stage
  logic [FACTOR_W-1:0] rd_total;
  logic [FACTOR_W-1:0] rd_core;

  ceb_tbl #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_tbl (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .we         (a_vld_r && a_we_r),
    .addr       (a_addr_r),
    .wdata_total(a_tf_r),
    .wdata_core (a_cf_r),
    .rd_total   (rd_total),
    .rd_core    (rd_core),
    .busy       (tbl_busy)
  );

  logic                m_vld_r;
  logic [ENERGY_W-1:0] m_en_r;
  logic [ENERGY_W-1:0] m_co_r;
  logic [EBW-1:0]      m_ebin_r;
  logic [PBW-1:0]      m_pbin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= a_vld_r && (a_func_r == FUNC_CLUSTER);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_en_r   <= a_en_r;
      m_co_r   <= a_co_r;
      m_ebin_r <= a_ebin_r;
      m_pbin_r <= a_pbin_r;
    end
  end

  // saturation check, energy division
  logic       sat_t;
  logic       sat_c;
  back_t      bt_in;

  always_comb begin
    sat_t       = {4'b0, m_en_r} >= {rd_total, 12'b0};
    sat_c       = {4'b0, m_co_r} >= {rd_core, 12'b0};
    bt_in.sat   = sat_t;
    bt_in.fault = (rd_total == '0) || (rd_core == '0);
    bt_in.ebin  = m_ebin_r;
    bt_in.pbin  = m_pbin_r;
  end

  logic                dt_vld;
  logic [ENERGY_W-1:0] dt_quo;
  back_t               dt_side;
  logic                dc_vld;
  logic [ENERGY_W-1:0] dc_quo;
  logic                dc_sat;

  ceb_div #(
    .NUM_W (NUM_W),
    .DEN_W (FACTOR_W),
    .Q_W   (ENERGY_W),
    .SPS   (2),
    .SIDE_W($bits(back_t))
  ) u_total_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (m_vld_r),
    .in_num   (sat_t ? '0 : {m_en_r, 12'b0}),
    .in_den   (rd_total),
    .in_side  (bt_in),
    .out_valid(dt_vld),
    .out_quo  (dt_quo),
    .out_side (dt_side)
  );

  ceb_div #(
    .NUM_W (NUM_W),
    .DEN_W (FACTOR_W),
    .Q_W   (ENERGY_W),
    .SPS   (2),
    .SIDE_W(1)
  ) u_core_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (m_vld_r),
    .in_num   (sat_c ? '0 : {m_co_r, 12'b0}),
    .in_den   (rd_core),
    .in_side  (sat_c),
    .out_valid(dc_vld),
    .out_quo  (dc_quo),
    .out_side (dc_sat)
  );

  // output register
  logic [ENERGY_W-1:0] out_energy_r;
  logic [ENERGY_W-1:0] out_core_r;
  logic [EBW-1:0]      out_ebin_r;
  logic [PBW-1:0]      out_pbin_r;
  logic                out_fault_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dt_vld && dc_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_energy_r <= dt_side.sat ? '1 : dt_quo;
      out_core_r   <= dc_sat ? '1 : dc_quo;
      out_ebin_r   <= dt_side.ebin;
      out_pbin_r   <= dt_side.pbin;
      out_fault_r  <= dt_side.fault;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_corrected_energy = out_energy_r;
  assign out_corrected_core   = out_core_r;
  assign out_eta_bin          = out_ebin_r;
  assign out_phi_bin          = out_pbin_r;
  assign out_divide_fault     = out_fault_r;

endmodule

// File: sim/tb_cluster_energy_bin_recalibrator.sv
// Testbench for cluster_energy_bin_recalibrator: directed table, then random
// writes and clusters checked against an in-bench predictor. Depends on ceb_pkg and cluster_energy_bin_recalibrator.
`timescale 1ns / 100ps
module tb_cluster_energy_bin_recalibrator;
  import ceb_pkg::*;

  typedef struct {
    logic        func;
    logic [8:0]  te;
    logic [5:0]  tp;
    logic [15:0] tf;
    logic [15:0] cf;
    logic [15:0] phi;
    logic [15:0] eta;
    logic [23:0] en;
    logic [23:0] co;
  } stim_t;

  typedef struct {
    logic [23:0] ce;
    logic [23:0] cc;
    logic [8:0]  eb;
    logic [5:0]  pb;
    logic        flt;
  } calib_t;

  localparam int DEPTH = 384 * 64;
  localparam int NDIR = 14;
  localparam int WD_LIMIT = 120000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_func = 1'b0;
  logic [8:0] in_table_eta_bin = '0;
  logic [5:0] in_table_phi_bin = '0;
  logic [15:0] in_total_factor = '0;
  logic [15:0] in_core_factor = '0;
  logic signed [15:0] in_cluster_phi = '0;
  logic [15:0] in_cluster_abs_eta = '0;
  logic [23:0] in_cluster_energy = '0;
  logic [23:0] in_cluster_core = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [23:0] out_corrected_energy;
  logic [23:0] out_corrected_core;
  logic [8:0] out_eta_bin;
  logic [5:0] out_phi_bin;
  logic out_divide_fault;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cluster_energy_bin_recalibrator dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [15:0] tot_tbl [DEPTH];
  logic [15:0] core_tbl [DEPTH];
  logic [15:0] lim_q;
  logic [8:0]  ebins_q;
  logic [6:0]  pbins_q;
  calib_t pending_calib[$];
  int errors = 0, mism = 0, n_clusters = 0, n_writes = 0, n_faults = 0, n_cfg = 0;
  int in_pct = 0, st_pct = 0, wd = 0;

  function automatic logic [23:0] divide_energy(logic [23:0] en, logic [15:0] f,
                                                 inout logic flt);
    longint unsigned q;
    if (f == 0) begin
      flt = 1'b1;
      return 24'hFFFFFF;
    end
    q = (longint'(en) * 4096) / f;
    return (q > 24'hFFFFFF) ? 24'hFFFFFF : q[23:0];
  endfunction

  function automatic calib_t recalibrate(stim_t s);
    calib_t r;
    int unsigned m, n, rr, pb, eb, idx;
    int t;
    logic flt;
    m = (ebins_q < 1) ? 1 : (ebins_q > 384) ? 384 : ebins_q;
    n = (pbins_q < 1) ? 1 : (pbins_q > 64) ? 64 : pbins_q;
    t = $signed(s.phi) * 32 + 32768;
    rr = t & 32'hFFFF;
    pb = (rr * n) >> 16;
    if (s.eta >= lim_q) eb = m - 1;
    else begin
      eb = (s.eta * m) / lim_q;
      if (eb > m - 1) eb = m - 1;
    end
    idx = eb * 64 + pb;
    flt = 1'b0;
    r.ce = divide_energy(s.en, tot_tbl[idx], flt);
    r.cc = divide_energy(s.co, core_tbl[idx], flt);
    r.eb = eb[8:0];
    r.pb = pb[5:0];
    r.flt = flt;
    return r;
  endfunction

  function automatic stim_t mk(bit f, int te, int tp, int tf, int cf, int phi, int eta,
                               int en, int co);
    stim_t s;
    s.func = f ? FUNC_CLUSTER : FUNC_WRITE;
    s.te = 9'(te); s.tp = 6'(tp); s.tf = 16'(tf); s.cf = 16'(cf);
    s.phi = 16'(phi); s.eta = 16'(eta); s.en = 24'(en); s.co = 24'(co);
    return s;
  endfunction

  // returns once the item has transferred; typed expectation used when given
  task automatic send(stim_t s, bit use_typed, calib_t typed);
    calib_t exp_c;
    if ($urandom_range(99) < in_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < in_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= s.func;
    in_table_eta_bin <= s.te;
    in_table_phi_bin <= s.tp;
    in_total_factor <= s.tf;
    in_core_factor <= s.cf;
    in_cluster_phi <= s.phi;
    in_cluster_abs_eta <= s.eta;
    in_cluster_energy <= s.en;
    in_cluster_core <= s.co;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (s.func == FUNC_WRITE) begin
      n_writes++;
      if (s.te < 384) begin
        tot_tbl[s.te * 64 + s.tp] = s.tf;
        core_tbl[s.te * 64 + s.tp] = s.cf;
      end
    end else begin
      n_clusters++;
      if (use_typed) exp_c = typed;
      else exp_c = recalibrate(s);
      pending_calib = {pending_calib, exp_c};
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_calib.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_cfg++;
    case (idx)
      REG_ETA_LIMIT: lim_q = 16'(val);
      REG_ETA_BINS:  ebins_q = 9'(val);
      REG_PHI_BINS:  pbins_q = 7'(val);
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (st_pct > 0) out_stall <= ($urandom_range(99) < st_pct);
    else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    calib_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_calib.size() == 0) begin
        errors++;
        if (mism++ < 10) $display("unexpected result transfer at %0t", $realtime);
      end else begin
        e = pending_calib.pop_front();
        if (out_divide_fault) n_faults++;
        if (out_corrected_energy !== e.ce || out_corrected_core !== e.cc ||
            out_eta_bin !== e.eb || out_phi_bin !== e.pb || out_divide_fault !== e.flt) begin
          errors++;
          if (mism++ < 10)
            $display("mismatch: exp e=%0d c=%0d eb=%0d pb=%0d f=%0b got e=%0d c=%0d eb=%0d pb=%0d f=%0b",
                     e.ce, e.cc, e.eb, e.pb, e.flt, out_corrected_energy,
                     out_corrected_core, out_eta_bin, out_phi_bin, out_divide_fault);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      wd <= 0;
    else
      wd <= wd + 1;
    if (wd >= WD_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WD_LIMIT);
      $display("tb_cluster_energy_bin_recalibrator: FAIL");
      $finish;
    end
  end

  stim_t dir_rows [NDIR];
  calib_t dir_exp [NDIR];
  bit dir_typed [NDIR];

  initial begin
    stim_t s;
    calib_t none;
    int unsigned mcur, ncur;
    none = '{default: '0};
    for (int i = 0; i < DEPTH; i++) begin
      tot_tbl[i] = UNITY_Q12;
      core_tbl[i] = UNITY_Q12;
    end
    lim_q = ETA_LIMIT_RST;
    ebins_q = 9'd384;
    pbins_q = 7'd64;

    dir_rows[0]  = mk(1, 0, 0, 0, 0, 0, 0, 1000, 1000);
    dir_rows[1]  = mk(1, 0, 0, 0, 0, -32768, 65535, 24'hFFFFFF, 0);
    dir_rows[2]  = mk(1, 0, 0, 0, 0, 32767, 4504, 0, 24'hFFFFFF);
    dir_rows[3]  = mk(0, 383, 32, 0, 0, 0, 0, 0, 0);
    dir_rows[4]  = mk(1, 0, 0, 0, 0, -32768, 65535, 5, 5);
    dir_rows[5]  = mk(0, 0, 32, 1, 65535, 0, 0, 0, 0);
    dir_rows[6]  = mk(1, 0, 0, 0, 0, 0, 0, 5000, 5000);
    dir_rows[7]  = mk(0, 511, 63, 0, 0, 0, 0, 0, 0);
    dir_rows[8]  = mk(0, 400, 0, 0, 0, 0, 0, 0, 0);
    dir_rows[9]  = mk(1, 0, 0, 0, 0, 1024, 2000, 123456, 654321);
    dir_rows[10] = mk(0, 100, 5, 65535, 8192, 0, 0, 0, 0);
    dir_rows[11] = mk(1, 0, 0, 0, 0, -1, 1, 24'h800000, 24'h7FFFFF);
    dir_rows[12] = mk(0, 383, 63, 2048, 16'hFFFF, 0, 0, 0, 0);
    dir_rows[13] = mk(1, 0, 0, 0, 0, 2047, 4505, 77, 16'hFFFF);
    dir_exp[0] = '{24'd1000, 24'd1000, 9'd0, 6'd32, 1'b0};
    dir_exp[1] = '{24'hFFFFFF, 24'd0, 9'd383, 6'd32, 1'b0};
    dir_exp[4] = '{24'hFFFFFF, 24'hFFFFFF, 9'd383, 6'd32, 1'b1};
    dir_typed[0] = 1; dir_typed[1] = 1; dir_typed[4] = 1;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NDIR; i++) send(dir_rows[i], dir_typed[i], dir_exp[i]);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin write_reg(REG_ETA_LIMIT, 0); write_reg(REG_ETA_BINS, 0);
                 write_reg(REG_PHI_BINS, 0); end
        1: begin write_reg(REG_ETA_LIMIT, 16'hFFFF); write_reg(REG_ETA_BINS, 16'h1FF);
                 write_reg(REG_PHI_BINS, 16'h7F); end
        2: begin write_reg(REG_ETA_LIMIT, 1); write_reg(REG_ETA_BINS, 1);
                 write_reg(REG_PHI_BINS, 1); end
        3: begin write_reg(REG_ETA_LIMIT, 4505); write_reg(REG_ETA_BINS, 4);
                 write_reg(REG_PHI_BINS, 4); end
        4: begin write_reg(REG_ETA_LIMIT, $urandom_range(65535, 1));
                 write_reg(REG_ETA_BINS, $urandom_range(16, 1));
                 write_reg(REG_PHI_BINS, $urandom_range(8, 1)); end
        default: begin write_reg(REG_ETA_LIMIT, ETA_LIMIT_RST);
                 write_reg(REG_ETA_BINS, 384); write_reg(REG_PHI_BINS, 64); end
      endcase
      case (ph % 4)
        0: begin in_pct = 0;  st_pct = 0;  end
        1: begin in_pct = 69; st_pct = 0;  end
        2: begin in_pct = 0;  st_pct = 69; end
        default: begin in_pct = 7; st_pct = 7; end
      endcase
      mcur = (ebins_q < 1) ? 1 : (ebins_q > 384) ? 384 : ebins_q;
      ncur = (pbins_q < 1) ? 1 : (pbins_q > 64) ? 64 : pbins_q;
      for (int k = 0; k < 225; k++) begin
        if (k == 112 && ph == 3) drain();
        s.func = ($urandom_range(99) < 70) ? FUNC_CLUSTER : FUNC_WRITE;
        s.te = ($urandom_range(99) < 70) ? 9'($urandom_range(mcur - 1)) : 9'($urandom);
        s.tp = ($urandom_range(99) < 70) ? 6'($urandom_range(ncur - 1)) : 6'($urandom);
        case ($urandom_range(9))
          0: s.tf = '0;
          1: s.tf = UNITY_Q12;
          2, 3: s.tf = 16'($urandom_range(64, 1));
          default: s.tf = 16'($urandom);
        endcase
        case ($urandom_range(9))
          0: s.cf = '0;
          1: s.cf = UNITY_Q12;
          2, 3: s.cf = 16'($urandom_range(64, 1));
          default: s.cf = 16'($urandom);
        endcase
        s.phi = 16'($urandom);
        s.eta = ($urandom_range(99) < 80 && lim_q > 0) ? 16'($urandom_range(lim_q))
                                                       : 16'($urandom);
        s.en = ($urandom_range(1)) ? 24'($urandom) : 24'($urandom_range(5000));
        s.co = ($urandom_range(1)) ? 24'($urandom) : 24'($urandom_range(5000));
        send(s, 1'b0, none);
      end
    end

    drain();
    if (pending_calib.size() != 0) errors++;
    $display("covered %0d clusters (%0d faulted), %0d table writes, %0d register writes",
             n_clusters, n_faults, n_writes, n_cfg);
    $display("six register settings incl. zero and all-ones, four idle/stall mixes");
    if (errors == 0) $display("tb_cluster_energy_bin_recalibrator: PASS");
    else $display("tb_cluster_energy_bin_recalibrator: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/ceb_pkg.sv
hw/rtl/ceb_div.sv
hw/rtl/ceb_tbl.sv
hw/rtl/cluster_energy_bin_recalibrator.sv
sim/tb_cluster_energy_bin_recalibrator.sv
